// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the priority queue.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TLPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TLPQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define TLPQ_ASSERT(lbl, prop, msg)

`define TLPQ_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== design/tlpq_pkg.sv =====
// Types and codes for the three-level priority queue.
// Depends on nothing.
package tlpq_pkg;

  localparam int unsigned LEVEL_COUNT = 3;
  localparam int unsigned WORD_W      = 32;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    LVL_HIGH = 2'd0,
    LVL_MED  = 2'd1,
    LVL_LOW  = 2'd2,
    LVL_NONE = 2'd3
  } level_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

endpackage

// ===== design/tlpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module tlpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// ===== design/three_level_priority_queue.sv =====
// Top level of the three-level strict-priority queue.
// Depends on tlpq_pkg, tlpq_ram and assert_macros.svh.
// One item per clock: busy stays low, so every cycle with start high takes an item
// (enqueue or dequeue). Each item gives exactly one result in the next cycle, with
// out_valid high for that single cycle; there is no way to stall the result side,
// so the receiver must take it then. The result is registered: it comes from the
// registered read port of the per-level word RAMs, which always read the head slot.
// An enqueue to a full queue or to level 3 is dropped and reported; a dequeue with
// all queues empty returns 0 with served level 3 and an empty status.
module three_level_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_kind,
  input  logic [1:0]             in_level,
  input  logic signed [31:0]     in_word_in,
  output logic                   out_valid,
  output logic signed [31:0]     out_word_out,
  output tlpq_pkg::level_t       out_served_level,
  output tlpq_pkg::status_t      out_status
);

  import tlpq_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FW-1:0] FULL_CNT = FW'(QUEUE_DEPTH);

  logic [IW-1:0] head_r [LEVEL_COUNT];
  logic [IW-1:0] head_nxt [LEVEL_COUNT];
  logic [IW-1:0] tail_r [LEVEL_COUNT];
  logic [IW-1:0] tail_nxt [LEVEL_COUNT];
  logic [FW-1:0] fill_r [LEVEL_COUNT];
  logic [FW-1:0] fill_nxt [LEVEL_COUNT];
  logic [LEVEL_COUNT-1:0] wr_en;
  logic [WORD_W-1:0] rdata [LEVEL_COUNT];

  logic    accept;
  logic    valid_r;
  level_t  served_r, served_nxt;
  status_t status_r, status_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
    return (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  always_comb begin
    logic found;
    logic enq_ok;
    found      = 1'b0;
    enq_ok     = 1'b0;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    wr_en      = '0;
    served_nxt = LVL_NONE;
    status_nxt = ST_OK;
    if (accept) begin
      case (in_kind)
        KIND_ENQ: begin
          for (int q = 0; q < LEVEL_COUNT; q++) begin
            if (in_level == 2'(q) && fill_r[q] != FULL_CNT) begin
              wr_en[q]    = 1'b1;
              tail_nxt[q] = next_slot(tail_r[q]);
              fill_nxt[q] = fill_r[q] + 1'b1;
              enq_ok      = 1'b1;
            end
          end
          status_nxt = enq_ok ? ST_OK : ST_DROPPED;
        end
        KIND_DEQ: begin
          // strict priority: lowest level number that holds a word wins
          for (int q = 0; q < LEVEL_COUNT; q++) begin
            if (!found && fill_r[q] != '0) begin
              found       = 1'b1;
              head_nxt[q] = next_slot(head_r[q]);
              fill_nxt[q] = fill_r[q] - 1'b1;
              served_nxt  = level_t'(2'(q));
            end
          end
          status_nxt = found ? ST_OK : ST_EMPTY;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int q = 0; q < LEVEL_COUNT; q++) begin
        head_r[q] <= '0;
        tail_r[q] <= '0;
        fill_r[q] <= '0;
      end
    end else begin
      valid_r <= accept;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    served_r <= served_nxt;
    status_r <= status_nxt;
  end

  for (genvar g = 0; g < LEVEL_COUNT; g++) begin : g_store
    tlpq_ram #(
      .WIDTH (WORD_W),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk     (clk),
      .we      (wr_en[g]),
      .waddr   (tail_r[g]),
      .wdata   (in_word_in),
      .raddr   (head_r[g]),
      .rdata_r (rdata[g])
    );
  end

  always_comb begin
    case (served_r)
      LVL_HIGH: out_word_out = rdata[0];
      LVL_MED:  out_word_out = rdata[1];
      LVL_LOW:  out_word_out = rdata[2];
      default:  out_word_out = '0;
    endcase
  end

  assign out_valid        = valid_r;
  assign out_served_level = served_r;
  assign out_status       = status_r;

  `TLPQ_ASSERT_NEVER(a_fill_bound,
    fill_r[0] > FULL_CNT || fill_r[1] > FULL_CNT || fill_r[2] > FULL_CNT,
    "fill count above depth")
  `TLPQ_ASSERT(a_one_result, accept |=> valid_r, "accepted item gave no result")
  `TLPQ_ASSERT(a_served_ok,
    valid_r && served_r != LVL_NONE |-> status_r == ST_OK,
    "served word with bad status")
  `TLPQ_ASSERT(a_empty_deq,
    accept && in_kind == KIND_DEQ && fill_r[0] == '0 && fill_r[1] == '0 &&
    fill_r[2] == '0 |=> status_r == ST_EMPTY,
    "empty dequeue not flagged")

endmodule
